// ===== sv/ttv_pkg.sv =====
package ttv_pkg;

    // default field widths
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int TEXCOORD_WIDTH_DEF = 24;

    // multiplier digit per step
    localparam int DIGIT_W = 8;
    // normalized magnitude width
    localparam int NORM_W = 31;
    // sum of squares and root widths
    localparam int SQ_W = 64;
    localparam int LEN_W = 32;
    localparam int SQRT_STEPS = 32;
    // output format
    localparam int FRAC_BITS = 14;
    localparam int QUO_W = 15;
    localparam int OUT_W = 16;
    localparam int DIV_W = NORM_W + FRAC_BITS + 1;
    // products per triangle and tangent components
    localparam int PROD_COUNT = 8;
    localparam int COMP_COUNT = 3;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic [1:0] slot;
        logic       mul_load;
        logic       mul_step;
        logic       mul_acc;
        logic [2:0] prod_idx;
        logic       norm_load;
        logic       norm_step;
        logic       sq_clear;
        logic       sq_mul;
        logic       sq_add;
        logic [1:0] comp_idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       out_load;
    } ttv_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic degen;
        logic norm_done;
    } ttv_status_t;

    // controller states, one-hot
    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_MLOAD     = 13'b0000000000010,
        ST_MSTEP     = 13'b0000000000100,
        ST_MACC      = 13'b0000000001000,
        ST_NLOAD     = 13'b0000000010000,
        ST_NORM      = 13'b0000000100000,
        ST_SQ        = 13'b0000001000000,
        ST_SQRT_INIT = 13'b0000010000000,
        ST_SQRT      = 13'b0000100000000,
        ST_DIV_INIT  = 13'b0001000000000,
        ST_DIV       = 13'b0010000000000,
        ST_DIV_STORE = 13'b0100000000000,
        ST_OUT       = 13'b1000000000000
    } ttv_state_t;

endpackage

// ===== sv/ttv_if.sv =====
// vertex channel
interface ttv_vertex_if #(
    parameter int POSITION_WIDTH = ttv_pkg::POSITION_WIDTH_DEF,
    parameter int TEXCOORD_WIDTH = ttv_pkg::TEXCOORD_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] pos_x;
    logic signed [POSITION_WIDTH-1:0] pos_y;
    logic signed [POSITION_WIDTH-1:0] pos_z;
    logic signed [TEXCOORD_WIDTH-1:0] tex_u;
    logic signed [TEXCOORD_WIDTH-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// tangent channel
interface ttv_tangent_if;
    logic                             valid;
    logic                             ready;
    logic signed [ttv_pkg::OUT_W-1:0] tangent_x;
    logic signed [ttv_pkg::OUT_W-1:0] tangent_y;
    logic signed [ttv_pkg::OUT_W-1:0] tangent_z;
    logic                             degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

// ===== sv/triangle_tangent_vector.sv =====
// Per-triangle unit tangent. First and second vertex of a triangle are captured while idle.
// The third vertex starts the work: eight products in the shared multiplier with ND digits each,
// ND = ceil((TEXCOORD_WIDTH+1)/8), then N = 0..max(30, POSITION_WIDTH+TEXCOORD_WIDTH-30) one-bit
// normalization shifts (N <= 30 at default widths), the 32-step square root and three 15-step
// divides. A degenerate triangle skips all but the products. Any result waits on the previous one.
// Reset (rst_n, asynchronous, low) clears the controller, the vertex slot and the output valid.
module triangle_tangent_vector #(
    parameter int POSITION_WIDTH = ttv_pkg::POSITION_WIDTH_DEF,
    parameter int TEXCOORD_WIDTH = ttv_pkg::TEXCOORD_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    ttv_vertex_if.sink  vertex,
    ttv_tangent_if.source tangent
);

    ttv_pkg::ttv_cmd_t    cmd;
    ttv_pkg::ttv_status_t status;

    // controller
    ttv_ctrl #(
        .TEXCOORD_WIDTH(TEXCOORD_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .in_ready (vertex.ready),
        .out_valid(tangent.valid),
        .out_ready(tangent.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ttv_dp #(
        .POSITION_WIDTH(POSITION_WIDTH),
        .TEXCOORD_WIDTH(TEXCOORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .status    (status),
        .pos_x     (vertex.pos_x),
        .pos_y     (vertex.pos_y),
        .pos_z     (vertex.pos_z),
        .tex_u     (vertex.tex_u),
        .tex_v     (vertex.tex_v),
        .tangent_x (tangent.tangent_x),
        .tangent_y (tangent.tangent_y),
        .tangent_z (tangent.tangent_z),
        .degenerate(tangent.degenerate)
    );

`ifndef SYNTHESIS
    // a degenerate result carries a zero tangent
    assert property (@(posedge clk) disable iff (!rst_n)
        (tangent.valid && tangent.degenerate) |->
        (tangent.tangent_x == 0 && tangent.tangent_y == 0 && tangent.tangent_z == 0))
    else $error("degenerate result with nonzero tangent");

    // components stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        tangent.valid |->
        (tangent.tangent_x <= 16384 && tangent.tangent_x >= -16384 &&
         tangent.tangent_y <= 16384 && tangent.tangent_y >= -16384 &&
         tangent.tangent_z <= 16384 && tangent.tangent_z >= -16384))
    else $error("tangent component out of range");

    // a new result is loaded only while vertex intake is stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !vertex.ready)
    else $error("result loaded while accepting vertices");
`endif

endmodule

// ===== sv/ttv_ctrl.sv =====
module ttv_ctrl #(
    parameter int TEXCOORD_WIDTH = ttv_pkg::TEXCOORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ttv_pkg::ttv_status_t status,
    output ttv_pkg::ttv_cmd_t    cmd
);

    localparam int BW = TEXCOORD_WIDTH + 1;
    localparam int ND = (BW + ttv_pkg::DIGIT_W - 1) / ttv_pkg::DIGIT_W;
    localparam int CW = $clog2(ttv_pkg::SQRT_STEPS);

    ttv_pkg::ttv_state_t state_reg, state_next;
    logic [1:0]    slot_reg, slot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          in_fire;

    assign in_ready  = (state_reg == ttv_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttv_pkg::ST_IDLE;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.slot       = slot_reg;
        cmd.prod_idx   = idx_reg;
        cmd.comp_idx   = idx_reg[1:0];
        cmd.capture    = in_fire;

        unique case (state_reg)
            ttv_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (slot_reg < 2'd2)
                    begin
                        slot_next = slot_reg + 2'd1;
                    end
                    else
                    begin
                        slot_next  = '0;
                        idx_next   = '0;
                        state_next = ttv_pkg::ST_MLOAD;
                    end
                end
            end
            ttv_pkg::ST_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = ttv_pkg::ST_MSTEP;
            end
            ttv_pkg::ST_MSTEP:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ND - 1))
                begin
                    state_next = ttv_pkg::ST_MACC;
                end
            end
            ttv_pkg::ST_MACC:
            begin
                cmd.mul_acc = 1'b1;
                idx_next    = idx_reg + 3'd1;
                if (idx_reg == 3'(ttv_pkg::PROD_COUNT - 1))
                begin
                    state_next = ttv_pkg::ST_NLOAD;
                end
                else
                begin
                    state_next = ttv_pkg::ST_MLOAD;
                end
            end
            ttv_pkg::ST_NLOAD:
            begin
                cmd.norm_load = 1'b1;
                cnt_next      = '0;
                if (status.degen)
                begin
                    state_next = ttv_pkg::ST_OUT;
                end
                else
                begin
                    state_next = ttv_pkg::ST_NORM;
                end
            end
            ttv_pkg::ST_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = ttv_pkg::ST_SQ;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ttv_pkg::ST_SQ:
            begin
                // square-and-add pipeline over three components
                cmd.comp_idx = cnt_reg[1:0];
                cmd.sq_clear = (cnt_reg == '0);
                cmd.sq_mul   = (cnt_reg < CW'(ttv_pkg::COMP_COUNT));
                cmd.sq_add   = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ttv_pkg::COMP_COUNT))
                begin
                    state_next = ttv_pkg::ST_SQRT_INIT;
                end
            end
            ttv_pkg::ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ttv_pkg::ST_SQRT;
            end
            ttv_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ttv_pkg::SQRT_STEPS - 1))
                begin
                    idx_next   = '0;
                    state_next = ttv_pkg::ST_DIV_INIT;
                end
            end
            ttv_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ttv_pkg::ST_DIV;
            end
            ttv_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ttv_pkg::QUO_W - 1))
                begin
                    state_next = ttv_pkg::ST_DIV_STORE;
                end
            end
            ttv_pkg::ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                idx_next      = idx_reg + 3'd1;
                if (idx_reg == 3'(ttv_pkg::COMP_COUNT - 1))
                begin
                    state_next = ttv_pkg::ST_OUT;
                end
                else
                begin
                    state_next = ttv_pkg::ST_DIV_INIT;
                end
            end
            ttv_pkg::ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ttv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ttv_dp.sv =====
module ttv_dp #(
    parameter int POSITION_WIDTH = ttv_pkg::POSITION_WIDTH_DEF,
    parameter int TEXCOORD_WIDTH = ttv_pkg::TEXCOORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  ttv_pkg::ttv_cmd_t                cmd,
    output ttv_pkg::ttv_status_t             status,
    input  logic signed [POSITION_WIDTH-1:0] pos_x,
    input  logic signed [POSITION_WIDTH-1:0] pos_y,
    input  logic signed [POSITION_WIDTH-1:0] pos_z,
    input  logic signed [TEXCOORD_WIDTH-1:0] tex_u,
    input  logic signed [TEXCOORD_WIDTH-1:0] tex_v,
    output logic signed [ttv_pkg::OUT_W-1:0] tangent_x,
    output logic signed [ttv_pkg::OUT_W-1:0] tangent_y,
    output logic signed [ttv_pkg::OUT_W-1:0] tangent_z,
    output logic                             degenerate
);

    localparam int PW  = POSITION_WIDTH;
    localparam int TW  = TEXCOORD_WIDTH;
    localparam int AW  = ((PW > TW) ? PW : TW) + 1;
    localparam int BW  = TW + 1;
    localparam int ND  = (BW + ttv_pkg::DIGIT_W - 1) / ttv_pkg::DIGIT_W;
    localparam int BMW = ND * ttv_pkg::DIGIT_W;
    localparam int ACW = AW + BW + 1;
    localparam int DW  = ttv_pkg::DIGIT_W;
    localparam int NW  = ttv_pkg::NORM_W;
    localparam int SW  = ttv_pkg::SQ_W;
    localparam int LW  = ttv_pkg::LEN_W;
    localparam int VW  = ttv_pkg::DIV_W;
    localparam int QW  = ttv_pkg::QUO_W;
    localparam int OW  = ttv_pkg::OUT_W;
    localparam int FB  = ttv_pkg::FRAC_BITS;

    logic signed [PW-1:0] pos_in [0:2];
    logic signed [PW-1:0] hp_reg [0:1][0:2];
    logic signed [TW-1:0] ht_reg [0:1][0:1];
    logic signed [PW:0]   e1_reg [0:2];
    logic signed [PW:0]   e2_reg [0:2];
    logic signed [TW:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [AW-1:0]      a_sel;
    logic signed [BW-1:0]      b_sel;
    logic signed [AW:0]        a_wide;
    logic signed [AW:0]        a_reg;
    logic [BMW-1:0]            bmag_reg;
    logic [DW-1:0]             digit;
    logic signed [AW+DW+1:0]   pp;
    logic signed [ACW-1:0]     prod_reg;
    logic signed [ACW-1:0]     det_reg;
    logic signed [ACW-1:0]     raw_reg [0:2];
    logic [ACW-1:0]            mag_reg [0:2];
    logic [ACW-1:0]            mag_or;
    logic                      neg_reg [0:2];
    logic                      flip_reg;
    logic [SW-1:0]             sqp_reg, s_reg;
    logic [SW-1:0]             rem_reg, root_reg, bit_reg, root_sum;
    logic [LW-1:0]             len;
    logic [VW-1:0]             drem_reg, dsr_reg;
    logic [QW-1:0]             q_reg;
    logic [OW-1:0]             q_ext;
    logic signed [OW-1:0]      tan_reg [0:2];
    logic                      det_zero, raw_zero;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    // vertex capture; edges and deltas on the third vertex
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (cmd.slot < 2'd2)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    hp_reg[cmd.slot[0]][c] <= pos_in[c];
                end
                ht_reg[cmd.slot[0]][0] <= tex_u;
                ht_reg[cmd.slot[0]][1] <= tex_v;
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                begin
                    e1_reg[c] <= (PW+1)'(hp_reg[1][c]) - (PW+1)'(hp_reg[0][c]);
                    e2_reg[c] <= (PW+1)'(pos_in[c]) - (PW+1)'(hp_reg[0][c]);
                end
                du1_reg <= (TW+1)'(ht_reg[1][0]) - (TW+1)'(ht_reg[0][0]);
                dv1_reg <= (TW+1)'(ht_reg[1][1]) - (TW+1)'(ht_reg[0][1]);
                du2_reg <= (TW+1)'(tex_u) - (TW+1)'(ht_reg[0][0]);
                dv2_reg <= (TW+1)'(tex_v) - (TW+1)'(ht_reg[0][1]);
            end
        end
    end

    // operand select: det products first, then raw tangent products
    always_comb
    begin
        unique case (cmd.prod_idx)
            3'd0:    a_sel = AW'(du1_reg);
            3'd1:    a_sel = AW'(du2_reg);
            3'd2:    a_sel = AW'(e1_reg[0]);
            3'd3:    a_sel = AW'(e2_reg[0]);
            3'd4:    a_sel = AW'(e1_reg[1]);
            3'd5:    a_sel = AW'(e2_reg[1]);
            3'd6:    a_sel = AW'(e1_reg[2]);
            3'd7:    a_sel = AW'(e2_reg[2]);
            default: a_sel = '0;
        endcase
        b_sel  = cmd.prod_idx[0] ? dv1_reg : dv2_reg;
        a_wide = (AW+1)'(a_sel);
    end

    assign digit = bmag_reg[BMW-1 -: DW];
    assign pp    = a_reg * $signed({1'b0, digit});

    // digit-serial signed multiply and product accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            a_reg    <= b_sel[BW-1] ? -a_wide : a_wide;
            bmag_reg <= BMW'(b_sel[BW-1] ? $unsigned(-b_sel) : $unsigned(b_sel));
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            bmag_reg <= bmag_reg << DW;
            prod_reg <= (prod_reg <<< DW) + ACW'(pp);
        end
        if (cmd.mul_acc)
        begin
            if (cmd.prod_idx[2:1] == 2'd0)
            begin
                det_reg <= cmd.prod_idx[0] ? det_reg - prod_reg : prod_reg;
            end
            else
            begin
                raw_reg[cmd.prod_idx[2:1] - 2'd1] <= cmd.prod_idx[0] ?
                    raw_reg[cmd.prod_idx[2:1] - 2'd1] - prod_reg : prod_reg;
            end
        end
    end

    // degenerate detect and normalization status
    always_comb
    begin
        det_zero = (det_reg == '0);
        raw_zero = (raw_reg[0] == '0) && (raw_reg[1] == '0) && (raw_reg[2] == '0);
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        status.degen     = det_zero || raw_zero;
        status.norm_done = mag_or[NW-1] && ((mag_or >> NW) == '0);
    end

    // magnitudes and one-bit block normalization
    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
        begin
            flip_reg <= det_reg[ACW-1];
            for (int c = 0; c < 3; c++)
            begin
                neg_reg[c] <= raw_reg[c][ACW-1];
                mag_reg[c] <= raw_reg[c][ACW-1] ? $unsigned(-raw_reg[c]) : $unsigned(raw_reg[c]);
            end
        end
        else if (cmd.norm_step)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((mag_or >> NW) != '0)
                begin
                    mag_reg[c] <= mag_reg[c] >> 1;
                end
                else
                begin
                    mag_reg[c] <= mag_reg[c] << 1;
                end
            end
        end
    end

    // sum of squares
    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
        begin
            sqp_reg <= SW'(mag_reg[cmd.comp_idx][NW-1:0] * mag_reg[cmd.comp_idx][NW-1:0]);
        end
        if (cmd.sq_clear)
        begin
            s_reg <= '0;
        end
        else if (cmd.sq_add)
        begin
            s_reg <= s_reg + sqp_reg;
        end
    end

    // integer square root, one result bit per step
    assign root_sum = root_reg + bit_reg;
    assign len      = root_reg[LW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rem_reg  <= s_reg;
            root_reg <= '0;
            bit_reg  <= SW'(1) << (SW - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= root_sum)
            begin
                rem_reg  <= rem_reg - root_sum;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // restoring divide with round-half-up numerator
    assign q_ext = OW'(q_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            drem_reg <= (VW'(mag_reg[cmd.comp_idx][NW-1:0]) << FB) + VW'(len >> 1);
            dsr_reg  <= VW'(len) << (QW - 1);
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (drem_reg >= dsr_reg)
            begin
                drem_reg <= drem_reg - dsr_reg;
                q_reg    <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
        if (cmd.div_store)
        begin
            tan_reg[cmd.comp_idx] <= (neg_reg[cmd.comp_idx] != flip_reg) ?
                -$signed(q_ext) : $signed(q_ext);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            degenerate <= status.degen;
            tangent_x  <= status.degen ? '0 : tan_reg[0];
            tangent_y  <= status.degen ? '0 : tan_reg[1];
            tangent_z  <= status.degen ? '0 : tan_reg[2];
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int PW = ttv_pkg::POSITION_WIDTH_DEF;
    localparam int TW = ttv_pkg::TEXCOORD_WIDTH_DEF;
    localparam int RANDOM_TRIS = 550;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
        logic signed [TW-1:0] u;
        logic signed [TW-1:0] v;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               degen;
    } tangent_t;

    // directed row: one vertex, plus a typed-in result on third vertices where obvious
    typedef struct {
        vertex_t  vtx;
        bit       has_fixed;
        tangent_t fixed;
    } vertex_row_t;

    logic clk;
    logic rst_n;
    longint cycle_count = 0;
    bit failed = 1'b0;
    bit table_failed = 1'b0;
    bit idle_enable;

    ttv_vertex_if #(.POSITION_WIDTH(PW), .TEXCOORD_WIDTH(TW)) vertex_ch ();
    ttv_tangent_if tangent_ch ();

    triangle_tangent_vector #(.POSITION_WIDTH(PW), .TEXCOORD_WIDTH(TW)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vertex_ch.sink),
        .tangent (tangent_ch.source)
    );

    // predictor state
    logic signed [PW-1:0] held_pos [6];
    logic signed [TW-1:0] held_tex [4];
    int unsigned tri_slot;
    tangent_t expected_tangents [$];

    always #5 clk = ~clk;

    function automatic logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit tangent of the triangle closed by vertex c
    function automatic tangent_t triangle_tangent(vertex_t c);
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [127:0] raw [3];
        logic [127:0] mag [3];
        logic [63:0] m [3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic signed [127:0] p2 [3];
        logic [63:0] s, len, q;
        int maxlen;
        tangent_t t;
        bit flip;
        p2[0] = c.px; p2[1] = c.py; p2[2] = c.pz;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = 128'(held_pos[3+i]) - 128'(held_pos[i]);
            e2[i] = p2[i] - 128'(held_pos[i]);
        end
        du1 = 128'(held_tex[2]) - 128'(held_tex[0]);
        dv1 = 128'(held_tex[3]) - 128'(held_tex[1]);
        du2 = 128'(c.u) - 128'(held_tex[0]);
        dv2 = 128'(c.v) - 128'(held_tex[1]);
        det = du1 * dv2 - du2 * dv1;
        flip = det < 0;
        maxlen = 0;
        for (int i = 0; i < 3; i++)
        begin
            raw[i] = dv2 * e1[i] - dv1 * e2[i];
            mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
            for (int k = 0; k < 128; k++)
                if (mag[i][k] && k + 1 > maxlen) maxlen = k + 1;
        end
        t = '0;
        if (det == 0 || maxlen == 0)
        begin
            t.degen = 1'b1;
            return t;
        end
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (maxlen > 31) m[i] = 64'(mag[i] >> (maxlen - 31));
            else m[i] = 64'(mag[i]) << (31 - maxlen);
            s = s + m[i] * m[i];
        end
        len = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 14) + (len >> 1)) / len;
            if ((raw[i] < 0) != flip) q = -q;
            if (i == 0) t.tx = q[15:0];
            else if (i == 1) t.ty = q[15:0];
            else t.tz = q[15:0];
        end
        return t;
    endfunction

    // advance the predictor on one accepted transaction
    task automatic track_vertex(vertex_t c);
        if (tri_slot < 2)
        begin
            held_pos[tri_slot*3] = c.px;
            held_pos[tri_slot*3+1] = c.py;
            held_pos[tri_slot*3+2] = c.pz;
            held_tex[tri_slot*2] = c.u;
            held_tex[tri_slot*2+1] = c.v;
            tri_slot++;
        end
        else
        begin
            expected_tangents.insert(expected_tangents.size(), triangle_tangent(c));
            tri_slot = 0;
        end
    endtask

    // send one vertex, with random idle bursts before it
    task automatic send_vertex(vertex_t c);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            vertex_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        vertex_ch.valid <= 1'b1;
        {vertex_ch.pos_x, vertex_ch.pos_y, vertex_ch.pos_z, vertex_ch.tex_u,
         vertex_ch.tex_v} <= c;
        @(posedge clk);
        while (!vertex_ch.ready) @(posedge clk);
        track_vertex(c);
    endtask

    function automatic vertex_t random_vertex(int mode);
        vertex_t c;
        c.px = $urandom; c.py = $urandom; c.pz = $urandom;
        c.u = TW'($urandom); c.v = TW'($urandom);
        if (mode == 1)
        begin
            // small mesh-like coordinates
            c.px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            c.py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            c.pz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            c.u = TW'($urandom_range(0, 1 << 17));
            c.v = TW'($urandom_range(0, 1 << 17));
        end
        else if (mode == 2)
        begin
            // tiny values for near-degenerate and short tangents
            c.px = $signed($urandom_range(0, 6)) - 3;
            c.py = $signed($urandom_range(0, 6)) - 3;
            c.pz = $signed($urandom_range(0, 6)) - 3;
            c.u = TW'($signed($urandom_range(0, 4)) - 2);
            c.v = TW'($signed($urandom_range(0, 4)) - 2);
        end
        return c;
    endfunction

    function automatic vertex_row_t row(vertex_t c, bit fx, tangent_t t);
        vertex_row_t r;
        r.vtx = c; r.has_fixed = fx; r.fixed = t;
        return r;
    endfunction

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result checking and receiver stalls
    int stall_left = 0;
    always @(posedge clk)
    begin
        tangent_t got, want;
        if (rst_n && tangent_ch.valid && tangent_ch.ready)
        begin
            got = {tangent_ch.tangent_x, tangent_ch.tangent_y, tangent_ch.tangent_z,
                   tangent_ch.degenerate};
            if (expected_tangents.size() == 0)
            begin
                $display("%0t: unexpected tangent transaction %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_tangents.pop_front();
                if (got.tx !== want.tx)
                begin
                    $display("%0t: tangent_x exp %0d got %0d", $time, want.tx, got.tx);
                    failed = 1'b1;
                end
                if (got.ty !== want.ty)
                begin
                    $display("%0t: tangent_y exp %0d got %0d", $time, want.ty, got.ty);
                    failed = 1'b1;
                end
                if (got.tz !== want.tz)
                begin
                    $display("%0t: tangent_z exp %0d got %0d", $time, want.tz, got.tz);
                    failed = 1'b1;
                end
                if (got.degen !== want.degen)
                begin
                    $display("%0t: degenerate exp %0b got %0b", $time, want.degen, got.degen);
                    failed = 1'b1;
                end
            end
        end
        if (!idle_enable)
            tangent_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            tangent_ch.ready <= (stall_left == 1);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(1, 19);
            tangent_ch.ready <= 1'b0;
        end
        else
            tangent_ch.ready <= 1'b1;
    end

    initial
    begin
        vertex_row_t rows [$];
        vertex_t zv, a, b, c;
        tangent_t zero_t, degen_t, unit_x, neg_x;
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        idle_enable = 1'b1;
        tri_slot = 0;
        foreach (held_pos[i]) held_pos[i] = '0;
        foreach (held_tex[i]) held_tex[i] = '0;
        vertex_ch.valid = 1'b0;
        {vertex_ch.pos_x, vertex_ch.pos_y, vertex_ch.pos_z, vertex_ch.tex_u,
         vertex_ch.tex_v} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zv = '0;
        zero_t = '0;
        degen_t = '0; degen_t.degen = 1'b1;
        unit_x = '0; unit_x.tx = 16'sd16384;
        neg_x = '0; neg_x.tx = -16'sd16384;

        // all-zero triangle: zero determinant
        rows.insert(rows.size(), row(zv, 0, zero_t));
        rows.insert(rows.size(), row(zv, 0, zero_t));
        rows.insert(rows.size(), row(zv, 1, degen_t));
        // unit triangle along x with u along x: tangent +x
        a = zv; b = zv; b.px = 32'sh10000; b.u = 24'sh10000;
        c = zv; c.py = 32'sh10000; c.v = 24'sh10000;
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        rows.insert(rows.size(), row(c, 1, unit_x));
        // mirrored UV: negative determinant flips the tangent
        b.u = -24'sh10000;
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        rows.insert(rows.size(), row(c, 1, neg_x));
        // nonzero determinant but collapsed positions: zero tangent length
        b.px = 0; c.py = 0;
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        rows.insert(rows.size(), row(c, 1, degen_t));
        // field extremes
        a = '1; a.px = 32'h80000000; a.u = 24'h800000;
        b = zv; b.py = 32'h7fffffff; b.v = 24'h7fffff; b.pz = 32'h80000000;
        c = zv; c.px = 32'h7fffffff; c.u = 24'h7fffff; c.v = 24'h800000;
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        rows.insert(rows.size(), row(c, 0, zero_t));
        rows.insert(rows.size(), row(c, 0, zero_t));
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        a = '1; b = zv; b.px = 1; b.u = 24'sd1; c = '1; c.v = 24'h7fffff;
        rows.insert(rows.size(), row(a, 0, zero_t));
        rows.insert(rows.size(), row(b, 0, zero_t));
        rows.insert(rows.size(), row(c, 0, zero_t));

        foreach (rows[i])
        begin
            send_vertex(rows[i].vtx);
            if (rows[i].has_fixed)
            begin
                if (expected_tangents.size() == 0 ||
                    expected_tangents[$] !== rows[i].fixed)
                begin
                    $display("%0t: directed row %0d exp %h got %h", $time, i,
                             rows[i].fixed, expected_tangents[$]);
                    table_failed = 1'b1;
                end
            end
        end

        // random triangles; last stretch runs without idling
        for (int n = 0; n < RANDOM_TRIS; n++)
        begin
            int mode;
            if (n == RANDOM_TRIS - 60) idle_enable = 1'b0;
            mode = $urandom_range(0, 5);
            mode = mode < 2 ? 0 : (mode < 5 ? 1 : 2);
            a = random_vertex(mode);
            b = random_vertex(mode);
            c = random_vertex(mode);
            if ($urandom_range(0, 9) == 0) c.u = a.u + (b.u - a.u);
            if ($urandom_range(0, 9) == 0) c = a;
            send_vertex(a);
            send_vertex(b);
            send_vertex(c);
        end
        vertex_ch.valid <= 1'b0;

        while (expected_tangents.size() > 0) @(posedge clk);
        wait_cycles = 400;
        repeat (wait_cycles) @(posedge clk);
        if (!failed && !table_failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
